// File: rtl/kks_pkg.sv
// Shared types, constants and keysym tables for the keycode to keysym translator.
`timescale 1ns / 1ps
`default_nettype none
package kks_pkg;

   // Field widths
   localparam int CODE_W  = 7;
   localparam int SYM_W   = 16;
   localparam int MOD_W   = 5;
   localparam int KEY_W   = 16;
   localparam int STATE_W = 2;

   // Codes at or above this value have no table entry
   localparam int TABLE_ENTRIES = 127;
   localparam int TABLE_SIZE    = 1 << CODE_W;

   localparam logic [CODE_W-1:0] KEY_LOGO_RIGHT = CODE_W'(126);

   // Modifier register bit positions
   localparam int MOD_CONTROL = 0;
   localparam int MOD_SHIFT   = 1;
   localparam int MOD_ALT     = 2;
   localparam int MOD_CAPS    = 3;
   localparam int MOD_LOGO    = 4;

   // Key state codes
   localparam logic [STATE_W-1:0] KEY_RELEASE = 2'd0;
   localparam logic [STATE_W-1:0] KEY_PRESS   = 2'd1;

   // Beat kind codes
   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_RESET = 1'b1;

   // Result status codes
   localparam logic STATUS_SENT    = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   // Selected keysyms
   localparam logic [SYM_W-1:0] SYM_ESCAPE     = 16'hff1b;
   localparam logic [SYM_W-1:0] SYM_LOGO_RIGHT = 16'hffe8;

   // Modifier behavior on press
   typedef enum logic {
      MOD_KIND_SET,
      MOD_KIND_TOGGLE
   } mod_kind_type;

   // One input beat
   typedef struct packed {
      logic               kind;
      logic [KEY_W-1:0]   key_code;
      logic [STATE_W-1:0] key_phase;
      logic               caps_led;
   } req_item_type;

   // One result beat
   typedef struct packed {
      logic              status;
      logic [CODE_W-1:0] out_code;
      logic [SYM_W-1:0]  keysym;
      logic [MOD_W-1:0]  modifiers;
   } rsp_item_type;

   // Unshifted US PC keysyms; the last entry pads the table to a power of two
   localparam logic [SYM_W-1:0] PLAIN_SYM [0:TABLE_SIZE-1] = '{
      16'h0000, SYM_ESCAPE, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
      16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002d, 16'h003d, 16'hff08, 16'hff09,
      16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
      16'h006f, 16'h0070, 16'h005b, 16'h005d, 16'hff0d, 16'hffe3, 16'h0061, 16'h0073,
      16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006a, 16'h006b, 16'h006c, 16'h003b,
      16'h0027, 16'h0060, 16'hffe1, 16'h005c, 16'h007a, 16'h0078, 16'h0063, 16'h0076,
      16'h0062, 16'h006e, 16'h006d, 16'h002c, 16'h002e, 16'h002f, 16'hffe2, 16'hffaa,
      16'hffe9, 16'h0020, 16'hffe5, 16'hffbe, 16'hffbf, 16'hffc0, 16'hffc1, 16'hffc2,
      16'hffc3, 16'hffc4, 16'hffc5, 16'hffc6, 16'hffc7, 16'hff7f, 16'hff14, 16'hff95,
      16'hff97, 16'hff9a, 16'hffad, 16'hff96, 16'hff9d, 16'hff98, 16'hffab, 16'hff9c,
      16'hff99, 16'hff9b, 16'hff9e, 16'hff9f, 16'h0000, 16'h0000, 16'h0000, 16'hffc8,
      16'hffc9, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hff8d, 16'hffe4, 16'hffaf, 16'h0000, 16'hffea, 16'hff0a, 16'hff50, 16'hff52,
      16'hff55, 16'hff51, 16'hff53, 16'hff57, 16'hff54, 16'hff56, 16'hff63, 16'hffff,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffbd, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffe7, SYM_LOGO_RIGHT, 16'h0000
   };

   // Shifted US PC keysyms; zero where shift has no effect
   localparam logic [SYM_W-1:0] SHIFTED_SYM [0:TABLE_SIZE-1] = '{
      16'h0000, 16'h0000, 16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h0025, 16'h005e,
      16'h0026, 16'h002a, 16'h0028, 16'h0029, 16'h005f, 16'h002b, 16'h0000, 16'h0000,
      16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055, 16'h0049,
      16'h004f, 16'h0050, 16'h007b, 16'h007d, 16'h0000, 16'h0000, 16'h0041, 16'h0053,
      16'h0044, 16'h0046, 16'h0047, 16'h0048, 16'h004a, 16'h004b, 16'h004c, 16'h003a,
      16'h0022, 16'h007e, 16'h0000, 16'h007c, 16'h005a, 16'h0058, 16'h0043, 16'h0056,
      16'h0042, 16'h004e, 16'h004d, 16'h003c, 16'h003e, 16'h003f, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
   };

endpackage
`default_nettype wire

// File: rtl/keycode_to_keysym_translator_core.sv
// Top level of the keycode to keysym translator: stream ports, pipeline registers.
// Usage:
//   Input beats arrive on the req_ stream. req_tuser carries the kind (0 key
//   event, 1 reload modifiers from the caps LED); req_tdata carries the key
//   code, the key state (0 release, 1 press, 2 repeat) and the caps LED.
//   Every input beat gives exactly one result beat on the rsp_ stream:
//   rsp_tuser is the status (0 key delivered, 1 ignored), rsp_tdata holds
//   the key code, the X keysym and the modifier bits after the event.
// Pipeline and throughput:
//   A beat is registered on entry, translated combinationally (table lookups
//   and the five-bit modifier update) and registered on exit. One beat is
//   taken every cycle while the output is not stalled; the modifier register
//   is updated as each beat moves into the output stage.
// Reset:
//   A synchronous reset empties both stages and clears the modifier bits.
// Back-pressure:
//   While rsp_tready is low the output beat holds; the input stage still
//   takes one more beat, after which req_tready falls until the output
//   register drains. Nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module keycode_to_keysym_translator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // [15:0] key_code, [17:16] key_state, [18] caps_led
   input  wire logic        req_tuser,  // [0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // [6:0] out_code, [22:7] keysym, [27:23] modifiers
   output logic             rsp_tuser   // [0] status
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   kks_pkg::req_item_type         in_item_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   kks_pkg::rsp_item_type         out_item_ff;
   logic [kks_pkg::MOD_W-1:0]     mods_ff;
   logic [kks_pkg::MOD_W-1:0]     mods_in;
   kks_pkg::rsp_item_type         xlat_result;
   logic                          out_free;
   logic                          advance;
   logic                          req_fire;

   // Handshake: the input stage drains whenever the output stage frees up
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !out_free);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   kks_translate u_translate (
      .item      (in_item_ff),
      .mods      (mods_ff),
      .result    (xlat_result),
      .mods_next (mods_in)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mods_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mods_ff <= mods_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.kind      <= req_tuser;
         in_item_ff.key_code  <= req_tdata[15:0];
         in_item_ff.key_phase <= req_tdata[17:16];
         in_item_ff.caps_led  <= req_tdata[18];
      end
      if (advance) begin
         out_item_ff <= xlat_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.status;
   assign rsp_tdata  = {4'b0000, out_item_ff.modifiers, out_item_ff.keysym,
                        out_item_ff.out_code};

   // A delivered key always carries a nonzero keysym
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.status == kks_pkg::STATUS_SENT)
         |-> (out_item_ff.keysym != '0))
      else $error("delivered beat with zero keysym");

   // An ignored beat carries no code and no keysym
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_item_ff.status == kks_pkg::STATUS_IGNORED)
         |-> (out_item_ff.keysym == '0 && out_item_ff.out_code == '0))
      else $error("ignored beat with payload");

   // Modifier bits move only with a beat passing into the output stage
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(mods_ff))
      else $error("modifier bits changed without a beat");

   // A reload beat leaves only the lock bit, taken from the caps LED
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.kind == kks_pkg::KIND_RESET)
         |=> (mods_ff == {1'b0, $past(in_item_ff.caps_led), 3'b000}))
      else $error("modifier reload mismatch");

   // The result register mirrors the modifier state it left behind
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_item_ff.modifiers == mods_ff))
      else $error("result modifiers differ from state");

endmodule
`default_nettype wire

// File: rtl/kks_translate.sv
// Single-pass translation of one key beat: modifier update and keysym lookup.
`timescale 1ns / 1ps
`default_nettype none
module kks_translate (
   input  wire kks_pkg::req_item_type       item,
   input  wire logic [kks_pkg::MOD_W-1:0]   mods,
   output kks_pkg::rsp_item_type            result,
   output logic [kks_pkg::MOD_W-1:0]        mods_next
);

   logic [kks_pkg::CODE_W-1:0] code;
   logic                       known;
   logic [kks_pkg::MOD_W-1:0]  mod_mask;
   kks_pkg::mod_kind_type      mod_kind;
   logic [kks_pkg::SYM_W-1:0]  plain_sym;
   logic [kks_pkg::SYM_W-1:0]  shift_sym;
   logic [kks_pkg::SYM_W-1:0]  caps_sym;
   logic [kks_pkg::SYM_W-1:0]  sym;
   logic                       sent;

   assign code  = item.key_code[kks_pkg::CODE_W-1:0];
   assign known = (item.key_code[kks_pkg::KEY_W-1:kks_pkg::CODE_W] == '0) &&
                  (code != kks_pkg::CODE_W'(kks_pkg::TABLE_ENTRIES));

   // Modifier key decode
   always_comb begin
      mod_mask = '0;
      mod_kind = kks_pkg::MOD_KIND_SET;
      case (code)
         7'd29, 7'd97:                 mod_mask[kks_pkg::MOD_CONTROL] = 1'b1;
         7'd42, 7'd54:                 mod_mask[kks_pkg::MOD_SHIFT]   = 1'b1;
         7'd56, 7'd100:                mod_mask[kks_pkg::MOD_ALT]     = 1'b1;
         7'd125, kks_pkg::KEY_LOGO_RIGHT: mod_mask[kks_pkg::MOD_LOGO] = 1'b1;
         7'd58: begin
            mod_mask[kks_pkg::MOD_CAPS] = 1'b1;
            mod_kind = kks_pkg::MOD_KIND_TOGGLE;
         end
         default: mod_mask = '0;
      endcase
   end

   // Table lookups: shift, then caps lock on letters, then plain
   assign plain_sym = kks_pkg::PLAIN_SYM[code];
   assign shift_sym = mods[kks_pkg::MOD_SHIFT] ? kks_pkg::SHIFTED_SYM[code] : '0;

   always_comb begin
      caps_sym = '0;
      if (mods[kks_pkg::MOD_CAPS] && (plain_sym inside {[16'h0061:16'h007a]})) begin
         caps_sym = plain_sym - 16'h0020;
      end
   end

   assign sym = (shift_sym != '0) ? shift_sym :
                (caps_sym != '0)  ? caps_sym  : plain_sym;

   // Modifier update and delivery decision
   always_comb begin
      mods_next = mods;
      sent      = 1'b0;
      if (item.kind == kks_pkg::KIND_RESET) begin
         mods_next = '0;
         mods_next[kks_pkg::MOD_CAPS] = item.caps_led;
      end else if (known) begin
         if (mod_mask != '0) begin
            if (item.key_phase == kks_pkg::KEY_PRESS) begin
               if (mod_kind == kks_pkg::MOD_KIND_SET) begin
                  mods_next = mods | mod_mask;
               end else begin
                  mods_next = mods ^ mod_mask;
               end
            end else if (item.key_phase == kks_pkg::KEY_RELEASE &&
                         mod_kind == kks_pkg::MOD_KIND_SET) begin
               mods_next = mods & ~mod_mask;
            end
         end else if (item.key_phase != kks_pkg::KEY_RELEASE) begin
            sent = (sym != '0);
         end
      end
   end

   assign result.status    = sent ? kks_pkg::STATUS_SENT : kks_pkg::STATUS_IGNORED;
   assign result.out_code  = sent ? code : '0;
   assign result.keysym    = sent ? sym : '0;
   assign result.modifiers = mods_next;

endmodule
`default_nettype wire

// File: tb/keysym_result_checker.sv
// Checker for the keycode to keysym translator: predicts each result beat and compares it.
`timescale 1ns / 1ps
module keysym_result_checker
   import kks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          error_count,
   output int          pending_count
);

   localparam int SHIFTED_ENTRIES = 54;

   // US PC layout, no modifiers
   localparam logic [SYM_W-1:0] US_PLAIN [0:TABLE_ENTRIES-1] = '{
      16'h0000, 16'hff1b, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036,
      16'h0037, 16'h0038, 16'h0039, 16'h0030, 16'h002d, 16'h003d, 16'hff08, 16'hff09,
      16'h0071, 16'h0077, 16'h0065, 16'h0072, 16'h0074, 16'h0079, 16'h0075, 16'h0069,
      16'h006f, 16'h0070, 16'h005b, 16'h005d, 16'hff0d, 16'hffe3, 16'h0061, 16'h0073,
      16'h0064, 16'h0066, 16'h0067, 16'h0068, 16'h006a, 16'h006b, 16'h006c, 16'h003b,
      16'h0027, 16'h0060, 16'hffe1, 16'h005c, 16'h007a, 16'h0078, 16'h0063, 16'h0076,
      16'h0062, 16'h006e, 16'h006d, 16'h002c, 16'h002e, 16'h002f, 16'hffe2, 16'hffaa,
      16'hffe9, 16'h0020, 16'hffe5, 16'hffbe, 16'hffbf, 16'hffc0, 16'hffc1, 16'hffc2,
      16'hffc3, 16'hffc4, 16'hffc5, 16'hffc6, 16'hffc7, 16'hff7f, 16'hff14, 16'hff95,
      16'hff97, 16'hff9a, 16'hffad, 16'hff96, 16'hff9d, 16'hff98, 16'hffab, 16'hff9c,
      16'hff99, 16'hff9b, 16'hff9e, 16'hff9f, 16'h0000, 16'h0000, 16'h0000, 16'hffc8,
      16'hffc9, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
      16'hff8d, 16'hffe4, 16'hffaf, 16'h0000, 16'hffea, 16'hff0a, 16'hff50, 16'hff52,
      16'hff55, 16'hff51, 16'hff53, 16'hff57, 16'hff54, 16'hff56, 16'hff63, 16'hffff,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffbd, 16'h0000, 16'h0000,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffe7, 16'hffe8
   };

   // Shifted layout; codes past the end have no shifted symbol
   localparam logic [SYM_W-1:0] US_SHIFTED [0:SHIFTED_ENTRIES-1] = '{
      16'h0000, 16'h0000, 16'h0021, 16'h0040, 16'h0023, 16'h0024, 16'h0025, 16'h005e,
      16'h0026, 16'h002a, 16'h0028, 16'h0029, 16'h005f, 16'h002b, 16'h0000, 16'h0000,
      16'h0051, 16'h0057, 16'h0045, 16'h0052, 16'h0054, 16'h0059, 16'h0055, 16'h0049,
      16'h004f, 16'h0050, 16'h007b, 16'h007d, 16'h0000, 16'h0000, 16'h0041, 16'h0053,
      16'h0044, 16'h0046, 16'h0047, 16'h0048, 16'h004a, 16'h004b, 16'h004c, 16'h003a,
      16'h0022, 16'h007e, 16'h0000, 16'h007c, 16'h005a, 16'h0058, 16'h0043, 16'h0056,
      16'h0042, 16'h004e, 16'h004d, 16'h003c, 16'h003e, 16'h003f
   };

   logic [MOD_W-1:0] held_mods;
   rsp_item_type     expected_results [$];

   // Modifier bit owned by a key code, zero for ordinary keys
   function automatic logic [MOD_W-1:0] modifier_mask(input logic [CODE_W-1:0] code);
      logic [MOD_W-1:0] mask;
      mask = '0;
      case (code)
         7'd29, 7'd97:  mask[MOD_CONTROL] = 1'b1;
         7'd42, 7'd54:  mask[MOD_SHIFT]   = 1'b1;
         7'd56, 7'd100: mask[MOD_ALT]     = 1'b1;
         7'd58:         mask[MOD_CAPS]    = 1'b1;
         7'd125, 7'd126: mask[MOD_LOGO]   = 1'b1;
         default:       mask = '0;
      endcase
      return mask;
   endfunction

   // Applies one key event to the held modifiers and returns the result beat
   function automatic rsp_item_type translate_key(input req_item_type beat);
      rsp_item_type     res;
      logic [MOD_W-1:0] hit;
      logic [CODE_W-1:0] code;
      logic [SYM_W-1:0] sym;
      res.status   = STATUS_IGNORED;
      res.out_code = '0;
      res.keysym   = '0;
      sym  = '0;
      code = beat.key_code[CODE_W-1:0];
      if (beat.kind == KIND_RESET) begin
         held_mods = '0;
         held_mods[MOD_CAPS] = beat.caps_led;
      end else if (beat.key_code < TABLE_ENTRIES) begin
         hit = modifier_mask(code);
         if (hit != '0) begin
            // caps lock toggles on press and ignores release
            if (beat.key_phase == KEY_PRESS)
               held_mods = hit[MOD_CAPS] ? (held_mods ^ hit) : (held_mods | hit);
            else if (beat.key_phase == KEY_RELEASE && !hit[MOD_CAPS])
               held_mods = held_mods & ~hit;
         end else if (beat.key_phase != KEY_RELEASE) begin
            if (held_mods[MOD_SHIFT] && code < SHIFTED_ENTRIES)
               sym = US_SHIFTED[code];
            if (sym == '0 && held_mods[MOD_CAPS] &&
                US_PLAIN[code] >= 16'h0061 && US_PLAIN[code] <= 16'h007a)
               sym = US_PLAIN[code] - 16'h0020;
            if (sym == '0)
               sym = US_PLAIN[code];
            if (sym != '0) begin
               res.status   = STATUS_SENT;
               res.out_code = code;
               res.keysym   = sym;
            end
         end
      end
      res.modifiers = held_mods;
      return res;
   endfunction

   task automatic note_mismatch(input string why, input rsp_item_type want,
                                input rsp_item_type got);
      if (error_count < 10) begin
         $display("%0t mismatch (%s): exp status %0d code %0d sym %h mods %b",
                  $realtime, why, want.status, want.out_code, want.keysym, want.modifiers);
         $display("%0t mismatch (%s): got status %0d code %0d sym %h mods %b",
                  $realtime, why, got.status, got.out_code, got.keysym, got.modifiers);
      end
      error_count++;
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
      held_mods     = '0;
   end

   // Pop and compare on each result beat, predict on each input beat
   always @(posedge clock) begin : watch_beats
      rsp_item_type got;
      rsp_item_type want;
      req_item_type beat;
      if (reset) begin
         expected_results.delete();
         held_mods = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tuser;
            got.out_code  = rsp_tdata[6:0];
            got.keysym    = rsp_tdata[22:7];
            got.modifiers = rsp_tdata[27:23];
            if (expected_results.size() == 0) begin
               want = '0;
               note_mismatch("unexpected beat", want, got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want)
                  note_mismatch("field", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            beat.kind      = req_tuser;
            beat.key_code  = req_tdata[15:0];
            beat.key_phase = req_tdata[17:16];
            beat.caps_led  = req_tdata[18];
            expected_results.push_back(translate_key(beat));
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

// File: tb/keycode_to_keysym_translator_core_tb.sv
// Testbench top for the keycode to keysym translator: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module keycode_to_keysym_translator_core_tb;
   import kks_pkg::*;

   localparam int                 ITEM_TARGET     = 1900;
   localparam logic [STATE_W-1:0] KEY_REPEAT      = 2'd2;
   localparam logic [STATE_W-1:0] KEY_PHASE_SPARE = 2'd3;
   localparam logic [KEY_W-1:0]   CAPS_LOCK_CODE  = 16'd58;

   // Normal modifiers: control, shift, alt, logo (left and right)
   localparam logic [KEY_W-1:0] NORMAL_MODS [0:7] = '{
      16'd29, 16'd97, 16'd42, 16'd54, 16'd56, 16'd100, 16'd125, 16'd126
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   int          error_count;
   int          pending_count;
   int          beats_sent;
   bit          send_idle;
   bit          recv_idle;

   keycode_to_keysym_translator_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   keysym_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // One input beat; called and returns at a falling edge
   task automatic send_beat(input logic kind, input logic [KEY_W-1:0] code,
                            input logic [STATE_W-1:0] state, input logic led);
      int gap;
      gap = send_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b0, led, state, code};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic key_event(input logic [KEY_W-1:0] code, input logic [STATE_W-1:0] state);
      send_beat(KIND_KEY, code, state, 1'($urandom_range(0, 1)));
   endtask

   // Hold off the sender until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   // Modifiers held around a few keys with repeats, released in reverse
   task automatic type_phrase();
      logic [KEY_W-1:0] held [$];
      logic [KEY_W-1:0] code;
      int n_mods;
      int n_keys;
      int reps;
      n_mods = $urandom_range(0, 2);
      repeat (n_mods) begin
         code = NORMAL_MODS[3'($urandom_range(0, 7))];
         key_event(code, KEY_PRESS);
         held.push_back(code);
      end
      if ($urandom_range(0, 3) == 0) begin
         key_event(CAPS_LOCK_CODE, KEY_PRESS);
         key_event(CAPS_LOCK_CODE, $urandom_range(0, 1) ? KEY_RELEASE : KEY_REPEAT);
      end
      n_keys = $urandom_range(1, 4);
      repeat (n_keys) begin
         code = KEY_W'($urandom_range(1, TABLE_ENTRIES - 1));
         key_event(code, KEY_PRESS);
         reps = $urandom_range(0, 3);
         repeat (reps)
            key_event(code, ($urandom_range(0, 7) == 0) ? KEY_PHASE_SPARE : KEY_REPEAT);
         key_event(code, KEY_RELEASE);
      end
      while (held.size() > 0)
         key_event(held.pop_back(), KEY_RELEASE);
   endtask

   // Arbitrary beat: any kind, any code, any state
   task automatic noise_beat();
      logic [KEY_W-1:0] code;
      code = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 65535))
                                  : KEY_W'($urandom_range(0, TABLE_ENTRIES - 1));
      send_beat(($urandom_range(0, 9) == 0) ? KIND_RESET : KIND_KEY, code,
                STATE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
   endtask

   // Result side: random stall before each beat
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(0, 14) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // Stimulus and verdict
   initial begin
      int pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_KEY;
      beats_sent = 0;
      send_idle  = 1'b1;
      recv_idle  = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: plain, shifted, caps lock and each ignored case
      key_event(16'd30, KEY_PRESS);
      key_event(16'd42, KEY_PRESS);
      key_event(16'd30, KEY_PRESS);
      key_event(16'd2, KEY_PRESS);
      key_event(16'd28, KEY_REPEAT);
      key_event(16'd42, KEY_RELEASE);
      key_event(CAPS_LOCK_CODE, KEY_PRESS);
      key_event(16'd16, KEY_REPEAT);
      key_event(16'd2, KEY_PRESS);
      key_event(CAPS_LOCK_CODE, KEY_RELEASE);
      key_event(16'd54, KEY_PRESS);
      key_event(16'd44, KEY_PRESS);
      key_event(16'd29, KEY_REPEAT);
      key_event(16'd126, KEY_PRESS);
      key_event(16'd125, KEY_PRESS);
      key_event(16'd126, KEY_RELEASE);
      key_event(16'd0, KEY_PRESS);
      key_event(16'd30, KEY_RELEASE);
      key_event(16'd127, KEY_PRESS);
      send_beat(KIND_KEY, 16'hffff, KEY_PHASE_SPARE, 1'b1);
      key_event(16'd84, KEY_PRESS);
      key_event(16'd111, KEY_PHASE_SPARE);
      key_event(16'd97, KEY_PHASE_SPARE);
      send_beat(KIND_RESET, 16'd0, KEY_RELEASE, 1'b1);
      send_beat(KIND_RESET, 16'hffff, KEY_PHASE_SPARE, 1'b0);
      drain_results();

      // Random: mostly typed phrases, some resets and noise
      while (beats_sent < ITEM_TARGET) begin
         if (beats_sent % 150 < 8) begin
            send_idle = $urandom_range(0, 2) != 0;
            recv_idle = $urandom_range(0, 2) != 0;
         end
         if (beats_sent >= ITEM_TARGET / 2 && beats_sent < ITEM_TARGET / 2 + 8)
            drain_results();
         pick = $urandom_range(0, 9);
         if (pick < 6)
            type_phrase();
         else if (pick == 6)
            send_beat(KIND_RESET, KEY_W'($urandom_range(0, 65535)),
                      STATE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         else
            noise_beat();
      end

      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
